// File: rtl/goa_pkg.sv
// ----------------------------------------------------------------------------
// goa_pkg: shared types and helpers for the optimizer update engine
// Operation codes, register indexes, reset values and fixed-point helpers.
// ----------------------------------------------------------------------------
package goa_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int POS_W = $clog2(MAX_ELEMENTS);

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [2:0] MODE_SGD      = 3'd0;
  localparam logic [2:0] MODE_MOMENTUM = 3'd1;
  localparam logic [2:0] MODE_ADAM     = 3'd2;
  localparam logic [2:0] MODE_RMSPROP  = 3'd3;
  localparam logic [2:0] MODE_ADAGRAD  = 3'd4;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_RATE     = 3'd1;
  localparam logic [2:0] REG_MOMENTUM = 3'd2;
  localparam logic [2:0] REG_BETA1    = 3'd3;
  localparam logic [2:0] REG_BETA2    = 3'd4;
  localparam logic [2:0] REG_ALPHA    = 3'd5;
  localparam logic [2:0] REG_EPS      = 3'd6;

  localparam logic [15:0] RATE_RST     = 16'd655;
  localparam logic [15:0] MOMENTUM_RST = 16'd58982;
  localparam logic [15:0] BETA1_RST    = 16'd58982;
  localparam logic [15:0] BETA2_RST    = 16'd65470;
  localparam logic [15:0] ALPHA_RST    = 16'd64880;
  localparam logic [23:0] EPS_RST      = 24'd1;

  localparam int DIV_STEPS  = 56;
  localparam int SQRT_STEPS = 28;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SQ, OP_LRG, OP_STEPQ, OP_MUFM, OP_VEL,
    OP_LRV, OP_B1FM, OP_B1G, OP_MEAN, OP_B2SM, OP_B2G2, OP_SEC, OP_ALSM,
    OP_ALG2, OP_ADA, OP_DIVMH, OP_MH, OP_DIVVH, OP_VH, OP_SQRT, OP_DEN,
    OP_DIVST, OP_STDIV, OP_ZERO, OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       clr_last;
    logic       iter_busy;
    logic       out_free;
  } status_t;

  function automatic logic signed [50:0] q16_trunc(input logic signed [66:0] x);
    logic signed [66:0] t;
    t = x[66] ? x + 67'sd65535 : x;
    return t[66:16];
  endfunction

  function automatic logic [31:0] sat_s32(input logic signed [66:0] x);
    if (x > 67'sd2147483647) return 32'h7fff_ffff;
    if (x < -67'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

// File: rtl/goa_iter.sv
// ----------------------------------------------------------------------------
// goa_iter: shared divide and square root unit
// Restoring division one quotient bit per cycle, or integer square root one
// result bit per cycle, on a 56-bit operand.
// ----------------------------------------------------------------------------
module goa_iter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        sqrt_sel,
  input  logic [55:0] num,
  input  logic [29:0] den,
  output logic        busy,
  output logic [55:0] result
);

  logic        is_sqrt;
  logic [5:0]  cnt;
  logic [55:0] work;
  logic [31:0] rem;
  logic [27:0] root;
  logic [29:0] den_r;

  logic [31:0] div_sh;
  logic        div_ge;
  logic [31:0] sq_sh;
  logic [31:0] sq_trial;
  logic        sq_ge;

  assign div_sh   = {rem[30:0], work[55]};
  assign div_ge   = div_sh >= {2'b00, den_r};
  assign sq_sh    = {rem[29:0], work[55:54]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= sqrt_sel ? 6'(goa_pkg::SQRT_STEPS) : 6'(goa_pkg::DIV_STEPS);
    end else if (busy) begin
      cnt  <= cnt - 6'd1;
      busy <= cnt != 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      is_sqrt <= sqrt_sel;
      work    <= num;
      rem     <= '0;
      root    <= '0;
      den_r   <= den;
    end else if (busy) begin
      if (is_sqrt) begin
        work <= {work[53:0], 2'b00};
        if (sq_ge) begin
          rem  <= sq_sh - sq_trial;
          root <= {root[26:0], 1'b1};
        end else begin
          rem  <= sq_sh;
          root <= {root[26:0], 1'b0};
        end
      end else begin
        work <= {work[54:0], div_ge};
        rem  <= div_ge ? div_sh - {2'b00, den_r} : div_sh;
      end
    end
  end

  assign result = is_sqrt ? {28'd0, root} : work;

endmodule

// File: rtl/goa_datapath.sv
// ----------------------------------------------------------------------------
// goa_datapath: optimizer arithmetic, moment stores and output register
// Executes one operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
module goa_datapath (
  input  logic                clk,
  input  logic                rst,
  input  goa_pkg::cmd_t       cmd,
  output goa_pkg::status_t    status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_valid,
  input  logic signed [31:0]  in_param,
  input  logic signed [31:0]  in_grad,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_value,
  output logic                out_last
);

  localparam int PW = goa_pkg::POS_W;

  logic [2:0]  mode;
  logic [15:0] rate, mom, beta1, beta2, alpha;
  logic [23:0] eps;

  logic signed [31:0] fm_mem [goa_pkg::MAX_ELEMENTS];
  logic [31:0]        sm_mem [goa_pkg::MAX_ELEMENTS];

  logic [PW-1:0]      pos, idx, clr_addr;
  logic [16:0]        fp, sp;
  logic signed [31:0] p_r, g_r, fm_rd, mval;
  logic [31:0]        sm_rd, g2, sval, magnum;
  logic               last_r, neg;
  logic signed [65:0] prod, acc;
  logic signed [34:0] step;
  logic [29:0]        rootden;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul;
  logic [31:0]        g_mag, m_mag;
  logic [16:0]        d1, d2;
  logic signed [66:0] vsum, bsum, prod_x;
  logic [50:0]        shs;
  logic [32:0]        ada_sum;
  logic signed [35:0] diff;
  logic [29:0]        rsum;
  logic [33:0]        scap;
  logic               iter_start, iter_sqrt, iter_busy;
  logic [55:0]        iter_num, iter_res;
  logic [29:0]        iter_den;
  logic               fm_we, sm_we;
  logic [PW-1:0]      wr_addr;
  logic signed [31:0] fm_wd;
  logic [31:0]        sm_wd, sval_new;
  logic               load, out_free;

  assign load     = (cmd.op == goa_pkg::OP_LOAD) && in_valid;
  assign out_free = !out_valid || out_ready;
  assign g_mag    = goa_pkg::mag32(g_r);
  assign m_mag    = goa_pkg::mag32(mval);
  assign d1       = (goa_pkg::ONE_Q16 == fp) ? 17'd1 : goa_pkg::ONE_Q16 - fp;
  assign d2       = (goa_pkg::ONE_Q16 == sp) ? 17'd1 : goa_pkg::ONE_Q16 - sp;
  assign prod_x   = 67'(prod);
  assign vsum     = 67'(goa_pkg::q16_trunc(prod_x)) + 67'(g_r);
  assign bsum     = 67'(acc) + prod_x;
  assign shs      = bsum[66:16];
  assign sval_new = (|shs[50:32]) ? 32'hffff_ffff : shs[31:0];
  assign ada_sum  = {1'b0, sm_rd} + {1'b0, g2};
  assign diff     = 36'(p_r) - 36'(step);
  assign rsum     = 30'(iter_res[27:0]) + 30'(eps);
  assign scap     = (iter_res > 56'h2_0000_0000) ? 34'h2_0000_0000 : iter_res[33:0];

  always_comb begin
    mul_a = {g_r[31], g_r};
    mul_b = 33'(rate);
    case (cmd.op)
      goa_pkg::OP_SQ:   begin mul_a = {1'b0, g_mag}; mul_b = {1'b0, g_mag}; end
      goa_pkg::OP_LRG:  begin mul_a = {g_r[31], g_r}; mul_b = 33'(rate); end
      goa_pkg::OP_MUFM: begin mul_a = {fm_rd[31], fm_rd}; mul_b = 33'(mom); end
      goa_pkg::OP_LRV:  begin mul_a = {mval[31], mval}; mul_b = 33'(rate); end
      goa_pkg::OP_B1FM: begin mul_a = {fm_rd[31], fm_rd}; mul_b = 33'(beta1); end
      goa_pkg::OP_B1G: begin
        mul_a = {g_r[31], g_r};
        mul_b = 33'(goa_pkg::ONE_Q16 - {1'b0, beta1});
      end
      goa_pkg::OP_B2SM: begin mul_a = {1'b0, sm_rd}; mul_b = 33'(beta2); end
      goa_pkg::OP_B2G2: begin
        mul_a = {1'b0, g2};
        mul_b = 33'(goa_pkg::ONE_Q16 - {1'b0, beta2});
      end
      goa_pkg::OP_ALSM: begin mul_a = {1'b0, sm_rd}; mul_b = 33'(alpha); end
      goa_pkg::OP_ALG2: begin
        mul_a = {1'b0, g2};
        mul_b = 33'(goa_pkg::ONE_Q16 - {1'b0, alpha});
      end
      goa_pkg::OP_DEN:  begin mul_a = {1'b0, magnum}; mul_b = 33'(rate); end
      default: begin
        mul_a = {g_r[31], g_r};
        mul_b = 33'(rate);
      end
    endcase
  end

  assign mul = mul_a * mul_b;

  always_comb begin
    iter_start = 1'b0;
    iter_sqrt  = 1'b0;
    iter_num   = {8'd0, m_mag, 16'd0};
    iter_den   = 30'(d1);
    case (cmd.op)
      goa_pkg::OP_DIVMH: begin
        iter_start = 1'b1;
        iter_num   = {8'd0, m_mag, 16'd0};
        iter_den   = 30'(d1);
      end
      goa_pkg::OP_DIVVH: begin
        iter_start = 1'b1;
        iter_num   = {8'd0, sval, 16'd0};
        iter_den   = 30'(d2);
      end
      goa_pkg::OP_SQRT: begin
        iter_start = 1'b1;
        iter_sqrt  = 1'b1;
        iter_num   = {sval, 24'd0};
      end
      goa_pkg::OP_DIVST: begin
        iter_start = 1'b1;
        iter_num   = {prod[47:0], 8'd0};
        iter_den   = rootden;
      end
      default: begin
        iter_start = 1'b0;
      end
    endcase
  end

  goa_iter u_iter (
    .clk      (clk),
    .rst      (rst),
    .start    (iter_start),
    .sqrt_sel (iter_sqrt),
    .num      (iter_num),
    .den      (iter_den),
    .busy     (iter_busy),
    .result   (iter_res)
  );

  always_comb begin
    fm_we   = 1'b0;
    sm_we   = 1'b0;
    wr_addr = idx;
    fm_wd   = goa_pkg::sat_s32(vsum);
    sm_wd   = sval_new;
    case (cmd.op)
      goa_pkg::OP_CLEAR: begin
        fm_we   = 1'b1;
        sm_we   = 1'b1;
        wr_addr = clr_addr;
        fm_wd   = '0;
        sm_wd   = '0;
      end
      goa_pkg::OP_VEL: fm_we = 1'b1;
      goa_pkg::OP_MEAN: begin
        fm_we = 1'b1;
        fm_wd = goa_pkg::sat_s32(67'(goa_pkg::q16_trunc(bsum)));
      end
      goa_pkg::OP_SEC: sm_we = 1'b1;
      goa_pkg::OP_ADA: begin
        sm_we = 1'b1;
        sm_wd = ada_sum[32] ? 32'hffff_ffff : ada_sum[31:0];
      end
      default: begin
        fm_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[wr_addr] <= fm_wd;
    if (load) fm_rd <= fm_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[wr_addr] <= sm_wd;
    if (load) sm_rd <= sm_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= goa_pkg::MODE_SGD;
      rate  <= goa_pkg::RATE_RST;
      mom   <= goa_pkg::MOMENTUM_RST;
      beta1 <= goa_pkg::BETA1_RST;
      beta2 <= goa_pkg::BETA2_RST;
      alpha <= goa_pkg::ALPHA_RST;
      eps   <= goa_pkg::EPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        goa_pkg::REG_MODE:     mode  <= cfg_data[2:0];
        goa_pkg::REG_RATE:     rate  <= cfg_data[15:0];
        goa_pkg::REG_MOMENTUM: mom   <= cfg_data[15:0];
        goa_pkg::REG_BETA1:    beta1 <= cfg_data[15:0];
        goa_pkg::REG_BETA2:    beta2 <= cfg_data[15:0];
        goa_pkg::REG_ALPHA:    alpha <= cfg_data[15:0];
        goa_pkg::REG_EPS:      eps   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      clr_addr <= '0;
      fp       <= goa_pkg::ONE_Q16;
      sp       <= goa_pkg::ONE_Q16;
    end else begin
      if (cmd.op == goa_pkg::OP_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (load) begin
        pos <= (in_last || pos == PW'(goa_pkg::MAX_ELEMENTS - 1)) ? '0 : pos + 1'b1;
        if (pos == '0) begin
          fp <= 17'(({16'd0, fp} * {17'd0, beta1}) >> 16);
          sp <= 17'(({16'd0, sp} * {17'd0, beta2}) >> 16);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_r    <= in_param;
      g_r    <= in_grad;
      last_r <= in_last;
      idx    <= pos;
    end
    case (cmd.op)
      goa_pkg::OP_SQ: g2 <= (|mul[65:56]) ? 32'hffff_ffff : mul[55:24];
      goa_pkg::OP_LRG, goa_pkg::OP_MUFM, goa_pkg::OP_LRV, goa_pkg::OP_B1FM,
      goa_pkg::OP_B2SM, goa_pkg::OP_ALSM: prod <= mul;
      goa_pkg::OP_B1G, goa_pkg::OP_B2G2, goa_pkg::OP_ALG2: begin
        acc  <= prod;
        prod <= mul;
      end
      goa_pkg::OP_STEPQ: step <= 35'(goa_pkg::q16_trunc(prod_x));
      goa_pkg::OP_VEL:   mval <= goa_pkg::sat_s32(vsum);
      goa_pkg::OP_MEAN:  mval <= goa_pkg::sat_s32(67'(goa_pkg::q16_trunc(bsum)));
      goa_pkg::OP_SEC: begin
        sval   <= sval_new;
        magnum <= g_mag;
        neg    <= g_r[31];
      end
      goa_pkg::OP_ADA: begin
        sval   <= ada_sum[32] ? 32'hffff_ffff : ada_sum[31:0];
        magnum <= g_mag;
        neg    <= g_r[31];
      end
      goa_pkg::OP_MH: begin
        magnum <= (iter_res > 56'h8000_0000) ? 32'h8000_0000 : iter_res[31:0];
        neg    <= mval[31];
      end
      goa_pkg::OP_VH: sval <= (|iter_res[55:32]) ? 32'hffff_ffff : iter_res[31:0];
      goa_pkg::OP_DEN: begin
        rootden <= (rsum == '0) ? 30'd1 : rsum;
        prod    <= mul;
      end
      goa_pkg::OP_STDIV: step <= neg ? -35'(scap) : 35'(scap);
      goa_pkg::OP_ZERO:  step <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == goa_pkg::OP_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == goa_pkg::OP_FIN && out_free) begin
      out_value <= goa_pkg::sat_s32(67'(diff));
      out_last  <= last_r;
    end
  end

  assign status.mode      = mode;
  assign status.clr_last  = clr_addr == PW'(goa_pkg::MAX_ELEMENTS - 1);
  assign status.iter_busy = iter_busy;
  assign status.out_free  = out_free;

endmodule

// File: rtl/goa_ctrl.sv
// ----------------------------------------------------------------------------
// goa_ctrl: sequencing state machine of the optimizer update engine
// Steps the datapath through the operations of the selected update rule.
// ----------------------------------------------------------------------------
module goa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  goa_pkg::status_t status,
  output goa_pkg::cmd_t    cmd
);

  typedef enum logic [30:0] {
    ST_CLEAR = 31'd1 << 0,  ST_IDLE  = 31'd1 << 1,  ST_SQ    = 31'd1 << 2,
    ST_LRG   = 31'd1 << 3,  ST_STEPQ = 31'd1 << 4,  ST_MUFM  = 31'd1 << 5,
    ST_VEL   = 31'd1 << 6,  ST_LRV   = 31'd1 << 7,  ST_B1FM  = 31'd1 << 8,
    ST_B1G   = 31'd1 << 9,  ST_MEAN  = 31'd1 << 10, ST_B2SM  = 31'd1 << 11,
    ST_B2G2  = 31'd1 << 12, ST_SEC   = 31'd1 << 13, ST_ALSM  = 31'd1 << 14,
    ST_ALG2  = 31'd1 << 15, ST_ADA   = 31'd1 << 16, ST_DMH   = 31'd1 << 17,
    ST_WMH   = 31'd1 << 18, ST_MH    = 31'd1 << 19, ST_DVH   = 31'd1 << 20,
    ST_WVH   = 31'd1 << 21, ST_VH    = 31'd1 << 22, ST_SQGO  = 31'd1 << 23,
    ST_SQW   = 31'd1 << 24, ST_DEN   = 31'd1 << 25, ST_DVGO  = 31'd1 << 26,
    ST_DVW   = 31'd1 << 27, ST_STDIV = 31'd1 << 28, ST_ZERO  = 31'd1 << 29,
    ST_FIN   = 31'd1 << 30
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = goa_pkg::OP_NONE;
    case (state)
      ST_CLEAR: begin
        cmd.op = goa_pkg::OP_CLEAR;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.op = goa_pkg::OP_LOAD;
        if (in_valid) state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = goa_pkg::OP_SQ;
        case (status.mode)
          goa_pkg::MODE_SGD:      state_next = ST_LRG;
          goa_pkg::MODE_MOMENTUM: state_next = ST_MUFM;
          goa_pkg::MODE_ADAM:     state_next = ST_B1FM;
          goa_pkg::MODE_RMSPROP:  state_next = ST_ALSM;
          goa_pkg::MODE_ADAGRAD:  state_next = ST_ADA;
          default:                state_next = ST_ZERO;
        endcase
      end
      ST_LRG:   begin cmd.op = goa_pkg::OP_LRG;   state_next = ST_STEPQ; end
      ST_STEPQ: begin cmd.op = goa_pkg::OP_STEPQ; state_next = ST_FIN; end
      ST_MUFM:  begin cmd.op = goa_pkg::OP_MUFM;  state_next = ST_VEL; end
      ST_VEL:   begin cmd.op = goa_pkg::OP_VEL;   state_next = ST_LRV; end
      ST_LRV:   begin cmd.op = goa_pkg::OP_LRV;   state_next = ST_STEPQ; end
      ST_B1FM:  begin cmd.op = goa_pkg::OP_B1FM;  state_next = ST_B1G; end
      ST_B1G:   begin cmd.op = goa_pkg::OP_B1G;   state_next = ST_MEAN; end
      ST_MEAN:  begin cmd.op = goa_pkg::OP_MEAN;  state_next = ST_B2SM; end
      ST_B2SM:  begin cmd.op = goa_pkg::OP_B2SM;  state_next = ST_B2G2; end
      ST_B2G2:  begin cmd.op = goa_pkg::OP_B2G2;  state_next = ST_SEC; end
      ST_SEC: begin
        cmd.op     = goa_pkg::OP_SEC;
        state_next = (status.mode == goa_pkg::MODE_ADAM) ? ST_DMH : ST_SQGO;
      end
      ST_ALSM:  begin cmd.op = goa_pkg::OP_ALSM;  state_next = ST_ALG2; end
      ST_ALG2:  begin cmd.op = goa_pkg::OP_ALG2;  state_next = ST_SEC; end
      ST_ADA:   begin cmd.op = goa_pkg::OP_ADA;   state_next = ST_SQGO; end
      ST_DMH:   begin cmd.op = goa_pkg::OP_DIVMH; state_next = ST_WMH; end
      ST_WMH:   if (!status.iter_busy) state_next = ST_MH;
      ST_MH:    begin cmd.op = goa_pkg::OP_MH;    state_next = ST_DVH; end
      ST_DVH:   begin cmd.op = goa_pkg::OP_DIVVH; state_next = ST_WVH; end
      ST_WVH:   if (!status.iter_busy) state_next = ST_VH;
      ST_VH:    begin cmd.op = goa_pkg::OP_VH;    state_next = ST_SQGO; end
      ST_SQGO:  begin cmd.op = goa_pkg::OP_SQRT;  state_next = ST_SQW; end
      ST_SQW:   if (!status.iter_busy) state_next = ST_DEN;
      ST_DEN:   begin cmd.op = goa_pkg::OP_DEN;   state_next = ST_DVGO; end
      ST_DVGO:  begin cmd.op = goa_pkg::OP_DIVST; state_next = ST_DVW; end
      ST_DVW:   if (!status.iter_busy) state_next = ST_STDIV;
      ST_STDIV: begin cmd.op = goa_pkg::OP_STDIV; state_next = ST_FIN; end
      ST_ZERO:  begin cmd.op = goa_pkg::OP_ZERO;  state_next = ST_FIN; end
      ST_FIN: begin
        cmd.op = goa_pkg::OP_FIN;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/gradient_optimizer_update_top.sv
// ----------------------------------------------------------------------------
// gradient_optimizer_update_top: per-element optimizer update engine
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tlast
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata, tlast
//   cfg       in         cfg_we                       cfg_index, cfg_data
//
// One element is processed at a time. SGD and momentum need no divide; AdaGrad
// and RMSprop each wait on one square root and one divide, and Adam on one
// square root and three divides, in the shared divide and square root unit.
// After reset all 1024 entries of the moment stores are swept to zero, during
// which no element is accepted. A finished result waits in the output
// register while the next element is taken in and computed; a result that
// finds the register still full holds the sequence in its last cycle.
// ----------------------------------------------------------------------------
module gradient_optimizer_update_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // param_value [31:0], gradient [63:32]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // new_value [31:0]
  output logic        m_axis_tlast
);

  goa_pkg::cmd_t    cmd;
  goa_pkg::status_t status;

  goa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  goa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_param  (s_axis_tdata[31:0]),
    .in_grad   (s_axis_tdata[63:32]),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  assign s_axis_tready = cmd.op == goa_pkg::OP_LOAD;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("element accepted while another is in progress");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == goa_pkg::OP_CLEAR) |-> !s_axis_tready)
    else $error("input ready during store clearing");

  a_iter_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == goa_pkg::OP_DIVMH || cmd.op == goa_pkg::OP_DIVVH ||
     cmd.op == goa_pkg::OP_SQRT || cmd.op == goa_pkg::OP_DIVST) |-> !status.iter_busy)
    else $error("iterative unit started while busy");
`endif

endmodule
